>>> rtl/core/range_address_translation_table_defines.svh
// assertion macros for the range address translation table
// expects clk and arst_n in the scope of each use
`ifndef RANGE_ADDRESS_TRANSLATION_TABLE_DEFINES_SVH
`define RANGE_ADDRESS_TRANSLATION_TABLE_DEFINES_SVH

// consequent checked in the same cycle
`define RTAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define RTAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rtat_pkg.sv
// shared types and constants for the range address translation table
// no dependencies
`timescale 1ns / 1ps

package rtat_pkg;

	localparam int ENTRIES   = 16;
	localparam int ADDR_BITS = 48;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [IDX_W-1:0]     idx_t;

	localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_XLATE  = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_DUP       = 2'd3
	} status_t;

	typedef struct packed {
		addr_t device_base;
		addr_t length;
		addr_t host_base;
	} entry_t;

endpackage

>>> rtl/core/rtat_ifs.sv
// request and response channel interfaces, valid/ready handshake
// depends on rtat_pkg
`timescale 1ns / 1ps

interface rtat_req_if;
	import rtat_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	addr_t device_addr;
	addr_t region_length;
	addr_t host_base;

	modport source (output valid, output kind, output device_addr, output region_length,
		output host_base, input ready);
	modport sink (input valid, input kind, input device_addr, input region_length,
		input host_base, output ready);
endinterface

interface rtat_rsp_if;
	import rtat_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	addr_t   host_addr_out;
	addr_t   length_out;

	modport source (output valid, output status, output host_addr_out, output length_out,
		input ready);
	modport sink (input valid, input status, input host_addr_out, input length_out,
		output ready);
endinterface

>>> rtl/core/rtat_ram.sv
// generic single-write single-read ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module rtat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/range_address_translation_table.sv
// a request transfer starts a scan of every entry, then drain and done states; the response is registered
// one request at a time: ready only while idle, and the scan of the region ram reads
// one entry per cycle through its single read port
// reset: valid bits clear at once, no clearing pass; ram contents are not reset
// depends on rtat_pkg, rtat_ifs, rtat_ram and the assertion macro header
`timescale 1ns / 1ps

`include "range_address_translation_table_defines.svh"

module range_address_translation_table (
	input logic      clk,
	input logic      arst_n,
	rtat_req_if.sink   req,
	rtat_rsp_if.source rsp
);
	import rtat_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t  state_q;
	idx_t    scan_idx_q;
	idx_t    idx_s1;
	logic    v_s1;

	kind_t   kind_q;
	addr_t   addr_q;
	addr_t   len_q;
	addr_t   host_q;

	logic    hit_q;
	idx_t    hit_idx_q;
	addr_t   hit_base_q;
	addr_t   hit_host_q;
	addr_t   hit_len_q;
	addr_t   hit_off_q;
	logic    free_q;
	idx_t    free_idx_q;

	logic [ENTRIES-1:0] valid_q;

	logic    rsp_valid_q;
	status_t status_q;
	addr_t   hout_q;
	addr_t   lout_q;

	entry_t  rd_ent;
	entry_t  wr_ent;
	logic [$bits(entry_t)-1:0] rd_raw;
	logic    ram_we;

	logic    in_xfer;
	logic    done_fire;
	logic    ent_valid;
	logic    exact;
	logic [ADDR_BITS:0] diff;
	addr_t   off;
	logic    in_range;
	logic    better;
	logic    take;

	status_t status_d;
	addr_t   hout_d;
	addr_t   lout_d;

	assign in_xfer   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign wr_ent.device_base = addr_q;
	assign wr_ent.length      = len_q;
	assign wr_ent.host_base   = host_q;
	assign ram_we = done_fire && (kind_q == KIND_ADD) && !hit_q && free_q;

	rtat_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (free_idx_q),
		.wr_data (wr_ent),
		.rd_en   (state_q == S_SCAN),
		.rd_addr (scan_idx_q),
		.rd_data (rd_raw)
	);

	assign rd_ent = entry_t'(rd_raw);

	// compare stage on the entry read in the previous cycle
	always_comb begin
		ent_valid = valid_q[idx_s1];
		exact     = ent_valid && (rd_ent.device_base == addr_q);
		diff      = {1'b0, addr_q} - {1'b0, rd_ent.device_base};
		off       = diff[ADDR_BITS-1:0];
		// borrow set means base above address
		in_range  = ent_valid && !diff[ADDR_BITS] && (off < rd_ent.length);
		better    = !hit_q || (rd_ent.device_base < hit_base_q);
		if (kind_q == KIND_XLATE) begin
			take = in_range && better;
		end else begin
			take = exact && !hit_q;
		end
	end

	always_comb begin
		status_d = ST_OK;
		hout_d   = '0;
		lout_d   = '0;
		case (kind_q)
			KIND_ADD: begin
				if (hit_q) begin
					status_d = ST_DUP;
				end else if (!free_q) begin
					status_d = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (!hit_q) begin
					status_d = ST_NOT_FOUND;
				end
			end
			KIND_XLATE: begin
				if (hit_q) begin
					hout_d = hit_host_q + hit_off_q;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			KIND_LOOKUP: begin
				if (hit_q) begin
					hout_d = hit_host_q;
					lout_d = hit_len_q;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_idx_q  <= '0;
			v_s1        <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1        <= (state_q == S_SCAN);
			rsp_valid_q <= done_fire || (rsp_valid_q && !rsp.ready);
			if (v_s1 && take) begin
				hit_q <= 1'b1;
			end
			if (v_s1 && !ent_valid) begin
				free_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q    <= S_SCAN;
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
						if (ram_we) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (kind_q == KIND_REMOVE && hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (in_xfer) begin
			kind_q <= req.kind;
			addr_q <= req.device_addr;
			len_q  <= req.region_length;
			host_q <= req.host_base;
		end
		if (v_s1 && take) begin
			hit_idx_q  <= idx_s1;
			hit_base_q <= rd_ent.device_base;
			hit_host_q <= rd_ent.host_base;
			hit_len_q  <= rd_ent.length;
			hit_off_q  <= off;
		end
		// lowest free slot wins
		if (v_s1 && !ent_valid && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (done_fire) begin
			status_q <= status_d;
			hout_q   <= hout_d;
			lout_q   <= lout_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.host_addr_out = hout_q;
	assign rsp.length_out    = lout_q;

	`RTAT_ASSERT_NEXT(a_one_item_at_a_time, in_xfer, (state_q == S_SCAN) && !req.ready,
		"request transfer did not start a scan")
	`RTAT_ASSERT_NOW(a_scan_drained, state_q == S_DONE, !v_s1,
		"result formed while a compare was still pending")
	`RTAT_ASSERT_NEXT(a_add_sets_one, ram_we,
		$countones(valid_q) == $past($countones(valid_q)) + 1,
		"successful add did not set exactly one valid bit")
	`RTAT_ASSERT_NEXT(a_remove_clears_one, done_fire && (kind_q == KIND_REMOVE) && hit_q,
		$countones(valid_q) + 1 == $past($countones(valid_q)),
		"successful remove did not clear exactly one valid bit")

endmodule
